[hdl/pps_pkg.sv]
// Shared widths, codes and entry types for the preemptive priority scheduler.
// No dependencies; imported by pps_tables and preemptive_priority_scheduler.
`default_nettype none

package pps_pkg;

	localparam int SLOT_W      = 4;
	localparam int ARR_W       = 16;
	localparam int BURST_W     = 16;
	localparam int PRIO_W      = 8;
	localparam int TIME_W      = 21;
	localparam int PC_W        = 5;
	localparam int MAX_SLOTS_D = 16;
	localparam int PC_RESET    = 16;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// input kind carried in tuser
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// static process description, one word per slot
	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
		logic [ARR_W-1:0]   arrival;
	} proc_entry_t;

	// run-time progress, one word per slot
	typedef struct packed {
		logic [TIME_W-1:0]  start;
		logic [BURST_W-1:0] remaining;
	} run_entry_t;

	typedef struct packed {
		logic              idle;
		logic [SLOT_W-1:0] running_slot;
		logic              switched;
		logic [TIME_W-1:0] tick_time;
		logic              finished;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic [TIME_W-1:0] first_start;
		logic              all_done;
	} result_t;

endpackage

`default_nettype wire

[hdl/pps_tables.sv]
// Slot tables of the scheduler: process memory and run-state memory.
// Both are synchronous with registered read data. Depends on pps_pkg.
`default_nettype none

module pps_tables
	import pps_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_D,
	parameter int IDX_W     = $clog2(MAX_SLOTS)
) (
	input  wire logic        clk,
	input  wire logic        proc_we,
	input  wire logic [IDX_W-1:0] proc_waddr,
	input  wire proc_entry_t proc_wdata,
	input  wire logic [IDX_W-1:0] proc_raddr,
	output proc_entry_t      proc_rdata,
	input  wire logic        run_we,
	input  wire logic [IDX_W-1:0] run_waddr,
	input  wire run_entry_t  run_wdata,
	input  wire logic [IDX_W-1:0] run_raddr,
	output run_entry_t       run_rdata
);

	proc_entry_t proc_mem [MAX_SLOTS];
	run_entry_t  run_mem  [MAX_SLOTS];
	proc_entry_t proc_rd_q;
	run_entry_t  run_rd_q;

	always_ff @(posedge clk) begin
		if (proc_we) begin
			proc_mem[proc_waddr] <= proc_wdata;
		end
		proc_rd_q <= proc_mem[proc_raddr];
	end

	always_ff @(posedge clk) begin
		if (run_we) begin
			run_mem[run_waddr] <= run_wdata;
		end
		run_rd_q <= run_mem[run_raddr];
	end

	assign proc_rdata = proc_rd_q;
	assign run_rdata  = run_rd_q;

endmodule

`default_nettype wire

[hdl/preemptive_priority_scheduler.sv]
// Top level of the preemptive priority scheduler: sequencer, scan and result path.
// Depends on pps_pkg and pps_tables.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+----------------------------------
//  s_*     | s_tvalid s_tready s_tdata s_tuser    | load or tick transaction
//  m_*     | m_tvalid m_tready m_tdata m_tuser    | one result per tick
//  cfg_*   | cfg_valid cfg_ready cfg_data         | process_count register write
//
// A load writes both tables as it is accepted. A tick scans the counted slots one per cycle through the
// process memory read port, then passes DRAIN, FRD, FIN, WT and OUT before the next acceptance;
// a tick with no ready slot skips FRD and FIN.
// Reset clears control state, the per-slot work and start flags, time and the last
// slot; table contents stay unknown until a slot is loaded.
// The result waits in an output register; a stalled m_tready holds only the
// following tick at its final step, loads still pass.
`default_nettype none

module preemptive_priority_scheduler
	import pps_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // slot, arrival, burst, priority_req, zero pad
	input  wire logic [0:0]  s_tuser,   // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,   // running_slot, switched, tick_time, turnaround,
	                                    // waiting, first_start, all_done, zero pad
	output logic [1:0]       m_tuser,   // idle, finished
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [PC_W-1:0] cfg_data // process_count
);

	localparam int IDX_W = $clog2(MAX_SLOTS);
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_FRD   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_WT    = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]           state_q;
	logic [PC_W-1:0]      pc_q;
	logic [MAX_SLOTS-1:0] nz_q;       // slot has work left
	logic [MAX_SLOTS-1:0] started_q;  // slot has run at least once
	logic [TIME_W-1:0]    time_q;
	logic                 last_vld_q;
	logic [IDX_W-1:0]     last_idx_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     best_q;
	logic [PRIO_W-1:0]    best_prio_q;
	logic [TIME_W-1:0]    tat_q;
	logic [BURST_W-1:0]   burst_q;
	result_t              res_q;
	result_t              out_q;
	logic                 out_vld_q;

	// input unpacking
	logic              in_action;
	logic [SLOT_W-1:0] in_slot;
	proc_entry_t       in_proc;

	assign in_action       = s_tuser[0];
	assign in_slot         = s_tdata[3:0];
	assign in_proc.arrival = s_tdata[19:4];
	assign in_proc.burst   = s_tdata[35:20];
	assign in_proc.prio    = s_tdata[43:36];

	logic in_acc, load_acc, tick_acc, load_ok;
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign load_ok  = (32'(in_slot) < MAX_SLOTS);
	assign load_acc = in_acc && (in_action == ACT_LOAD) && load_ok;
	assign tick_acc = in_acc && (in_action == ACT_TICK);

	// take a count write only between ticks, so a scan always sees one bound
	assign cfg_ready = (state_q == S_IDLE);

	// counted slots, clamped to the table size
	logic [CNT_W-1:0]     n_w;
	logic [MAX_SLOTS-1:0] cnt_mask;
	always_comb begin
		if (32'(pc_q) > MAX_SLOTS) begin
			n_w = CNT_W'(MAX_SLOTS);
		end else begin
			n_w = CNT_W'(pc_q);
		end
		for (int i = 0; i < MAX_SLOTS; i++) begin
			cnt_mask[i] = (i < 32'(n_w));
		end
	end

	// tables
	proc_entry_t      proc_rd;
	run_entry_t       run_rd;
	logic [IDX_W-1:0] proc_raddr;
	logic             run_we;
	logic [IDX_W-1:0] run_waddr;
	run_entry_t       run_wdata;
	logic             fin_we;
	run_entry_t       fin_wdata;

	assign proc_raddr = (state_q == S_SCAN) ? idx_q : best_q;
	assign fin_we     = (state_q == S_FIN);
	assign run_we     = load_acc || fin_we;
	assign run_waddr  = fin_we ? best_q : IDX_W'(in_slot);
	always_comb begin
		if (fin_we) begin
			run_wdata = fin_wdata;
		end else begin
			run_wdata.remaining = in_proc.burst;
			run_wdata.start     = '0;
		end
	end

	pps_tables #(
		.MAX_SLOTS (MAX_SLOTS),
		.IDX_W     (IDX_W)
	) u_tables (
		.clk        (clk),
		.proc_we    (load_acc),
		.proc_waddr (IDX_W'(in_slot)),
		.proc_wdata (in_proc),
		.proc_raddr (proc_raddr),
		.proc_rdata (proc_rd),
		.run_we     (run_we),
		.run_waddr  (run_waddr),
		.run_wdata  (run_wdata),
		.run_raddr  (best_q),
		.run_rdata  (run_rd)
	);

	// scan compare on the entry read last cycle
	logic cand_rdy, cand_win, found_nx;
	assign cand_rdy = rd_vld_s1 && nz_q[rd_idx_s1]
		&& ({{(TIME_W-ARR_W){1'b0}}, proc_rd.arrival} <= time_q);
	assign cand_win = cand_rdy && (!found_q || (proc_rd.prio < best_prio_q));
	assign found_nx = found_q || cand_win;

	logic scan_last;
	assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == n_w);

	// in OUT, the output register loads when empty or when its result leaves this cycle
	logic out_load;
	assign out_load = (state_q == S_OUT) && (!out_vld_q || m_tready);

	// completion arithmetic on the best slot's words
	logic [BURST_W-1:0] rem_new;
	logic [TIME_W-1:0]  first_start;
	logic [TIME_W-1:0]  done_at;
	logic [TIME_W-1:0]  tat;
	logic [TIME_W-1:0]  burst_ext;
	logic [TIME_W-1:0]  wt;
	always_comb begin
		rem_new               = run_rd.remaining - BURST_W'(1);
		first_start           = started_q[best_q] ? run_rd.start : time_q;
		done_at               = (time_q < TIME_MAX) ? time_q + TIME_W'(1) : TIME_MAX;
		tat                   = done_at - {{(TIME_W-ARR_W){1'b0}}, proc_rd.arrival};
		fin_wdata.remaining   = rem_new;
		fin_wdata.start       = first_start;
		burst_ext             = {{(TIME_W-BURST_W){1'b0}}, burst_q};
		wt                    = (tat_q >= burst_ext) ? tat_q - burst_ext : '0;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_W'(PC_RESET);
		end else if (cfg_valid && cfg_ready) begin
			pc_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nz_q        <= '0;
			started_q   <= '0;
			time_q      <= '0;
			last_vld_q  <= 1'b0;
			last_idx_q  <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_prio_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			rd_idx_s1 <= idx_q;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (cand_win) begin
				found_q     <= 1'b1;
				best_q      <= rd_idx_s1;
				best_prio_q <= proc_rd.prio;
			end
			unique case (state_q)
				S_IDLE: begin
					if (load_acc) begin
						// rearm the slot, forget its start
						nz_q[IDX_W'(in_slot)]      <= (in_proc.burst != '0);
						started_q[IDX_W'(in_slot)] <= 1'b0;
					end
					if (tick_acc) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= (n_w == '0) ? S_DRAIN : S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + IDX_W'(1);
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last compare lands here; pick the path
					state_q <= found_nx ? S_FRD : S_WT;
				end
				S_FRD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					nz_q[best_q]      <= (rem_new != '0);
					started_q[best_q] <= 1'b1;
					last_vld_q        <= 1'b1;
					last_idx_q        <= best_q;
					state_q           <= S_WT;
				end
				S_WT: begin
					if (time_q < TIME_MAX) begin
						time_q <= time_q + TIME_W'(1);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result assembly, payload only
	always_ff @(posedge clk) begin
		if (state_q == S_DRAIN) begin
			res_q <= '{idle: !found_nx, running_slot: '0, switched: 1'b0,
				tick_time: time_q, finished: 1'b0, turnaround: '0, waiting: '0,
				first_start: '0, all_done: 1'b0};
		end
		if (state_q == S_FIN) begin
			res_q.running_slot <= SLOT_W'(best_q);
			res_q.switched     <= !last_vld_q || (last_idx_q != best_q);
			res_q.finished     <= (rem_new == '0);
			res_q.first_start  <= (rem_new == '0) ? first_start : '0;
			tat_q              <= tat;
			burst_q            <= proc_rd.burst;
		end
		if (state_q == S_WT) begin
			res_q.turnaround <= res_q.finished ? tat_q : '0;
			res_q.waiting    <= res_q.finished ? wt : '0;
			res_q.all_done   <= ((nz_q & cnt_mask) == '0);
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = {out_q.finished, out_q.idle};
	assign m_tdata  = {6'b0, out_q.all_done, out_q.first_start, out_q.waiting,
		out_q.turnaround, out_q.tick_time, out_q.switched, out_q.running_slot};

	// the scan never walks past the counted slots
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CNT_W'(idx_q) < n_w))
		else $error("scan index beyond counted slots");

	// the chosen slot still has work when its words are fetched
	a_best_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRD) |-> nz_q[best_q])
		else $error("selected slot has no work left");

	// a completing slot drops out of the ready set
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && rem_new == '0) |=> !nz_q[$past(best_q)])
		else $error("finished slot still marked with work");

	// an idle tick never reports a switch or a completion
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (!m_tdata[4] && !m_tuser[1]))
		else $error("idle tick reports switch or finish");

endmodule

`default_nettype wire
